// ----- src/kpi_pkg.sv -----
// ----------------------------------------------------------------------------
// kpi_pkg: shared types and constants of the keyframe path interpolator
// Table geometry, fixed-point widths and the front-to-back command record.
// ----------------------------------------------------------------------------
package kpi_pkg;

	localparam int MaxMarkers   = 64;
	localparam int IdxW         = $clog2(MaxMarkers);
	localparam int CntW         = IdxW + 1;
	localparam int FracBits     = 16;
	localparam int WW           = FracBits + 1;
	localparam int NComp        = 7;
	localparam int CompW        = 32;
	localparam int TickW        = 32;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_QUERY = 1'b1
	} op_t;

	typedef logic [NComp-1:0][CompW-1:0] comp_vec_t;

	// one command handed from the front to the back
	typedef struct packed {
		op_t             op;
		logic [IdxW-1:0] idx;
		logic [TickW-1:0] tick;
		comp_vec_t       comp;
	} cmd_t;

	// one result record
	typedef struct packed {
		logic      has_markers;
		comp_vec_t comp;
	} res_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_RD_FIRST,
		ST_CHK_FIRST,
		ST_RD_LAST,
		ST_CHK_LAST,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_DIV,
		ST_LERP,
		ST_OUT
	} bk_state_t;

endpackage

// ----- src/kpi_cmd_fifo.sv -----
// ----------------------------------------------------------------------------
// kpi_cmd_fifo: short command queue between front and back
// Two-entry queue of accepted items; decouples input from the worker.
// ----------------------------------------------------------------------------
module kpi_cmd_fifo (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          wr_en,
	input  kpi_pkg::cmd_t wr_data,
	output logic          full,
	input  logic          rd_en,
	output kpi_pkg::cmd_t rd_data,
	output logic          empty
);
	import kpi_pkg::*;

	cmd_t       mem_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full    = (cnt_q == 2'd2);
	assign empty   = (cnt_q == 2'd0);
	assign rd_data = mem_q[rp_q];

	// storage
	always_ff @(posedge clk) begin
		if (wr_en && !full) mem_q[wp_q] <= wr_data;
	end

	// pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (wr_en && !full) wp_q <= ~wp_q;
			if (rd_en && !empty) rp_q <= ~rp_q;
			cnt_q <= cnt_q + 2'(wr_en && !full) - 2'(rd_en && !empty);
		end
	end

endmodule

// ----- src/kpi_back.sv -----
// ----------------------------------------------------------------------------
// kpi_back: keyframe table, scan, weight division and interpolation
// Carries out loads and queries one at a time; single-entry result register.
// ----------------------------------------------------------------------------
module kpi_back (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [kpi_pkg::CntW-1:0] count,
	input  logic                  cmd_valid,
	input  kpi_pkg::cmd_t         cmd,
	output logic                  cmd_take,
	output logic                  res_valid,
	output kpi_pkg::res_t         res,
	input  logic                  res_take
);
	import kpi_pkg::*;

	localparam int DivN = TickW + FracBits;

	// table memory: one write, one registered read
	logic [TickW+NComp*CompW-1:0] tab [MaxMarkers];
	logic [TickW+NComp*CompW-1:0] rd_q;
	logic [IdxW-1:0]              raddr;
	logic                         wr_en;

	bk_state_t st_q, st_d;
	cmd_t      cur_q;
	logic [CntW-1:0]  n_q;
	logic [IdxW-1:0]  i_q;
	logic [TickW-1:0] t0_q;
	comp_vec_t        p0_q, p1_q;
	logic [TickW-1:0] s_q;
	logic [DivN-1:0]  num_q;
	logic [TickW:0]   rem_q;
	logic [5:0]       dcnt_q;
	logic [2:0]       c_q;
	logic [WW-1:0]    w_q;
	comp_vec_t        out_q;
	logic             hm_q;
	logic             rv_q;

	logic [TickW-1:0] rd_tick;
	comp_vec_t        rd_comp;
	assign rd_tick = rd_q[TickW+NComp*CompW-1 -: TickW];
	assign rd_comp = rd_q[NComp*CompW-1:0];

	assign wr_en = (st_q == ST_IDLE) && cmd_valid && (cmd.op == OP_LOAD);

	always_ff @(posedge clk) begin
		if (wr_en) tab[cmd.idx] <= {cmd.tick, cmd.comp};
		rd_q <= tab[raddr];
	end

	// read address per state
	always_comb begin
		unique case (st_q)
			ST_RD_FIRST: raddr = '0;
			ST_RD_LAST:  raddr = IdxW'(n_q - 1'b1);
			ST_SCAN_RD:  raddr = i_q;
			default:     raddr = i_q;
		endcase
	end

	// division step: restoring, one quotient bit a cycle
	logic [TickW:0] rem_sh;
	logic           ge;
	assign rem_sh = {rem_q[TickW-1:0], num_q[DivN-1]};
	assign ge     = rem_sh >= {1'b0, s_q};

	// interpolation of one component
	logic signed [CompW:0]      diff;
	logic signed [CompW+WW+1:0] prod;
	logic signed [CompW+WW+1:0] rnd;
	logic signed [CompW:0]      delta;
	assign diff  = $signed({p1_q[c_q][CompW-1], p1_q[c_q]})
		- $signed({p0_q[c_q][CompW-1], p0_q[c_q]});
	assign prod  = diff * $signed({1'b0, w_q});
	assign rnd   = prod + (CompW+WW+2)'(1 << (FracBits-1));
	assign delta = (CompW+1)'(rnd >>> FracBits);

	logic scan_hit, scan_end;
	logic [TickW-1:0] one_w;
	assign one_w = TickW'(1) << FracBits;

	// effective marker count
	logic n_d_zero;
	logic [CntW-1:0] n_sat;
	assign n_sat    = (count > CntW'(MaxMarkers)) ? CntW'(MaxMarkers) : count;
	assign n_d_zero = (n_sat == '0);

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: if (cmd_valid) begin
				if (cmd.op == OP_LOAD) st_d = ST_IDLE;
				else if (n_d_zero) st_d = ST_OUT;
				else st_d = ST_RD_FIRST;
			end
			ST_RD_FIRST:  st_d = ST_CHK_FIRST;
			ST_CHK_FIRST: st_d = (cur_q.tick <= rd_tick) ? ST_OUT : ST_RD_LAST;
			ST_RD_LAST:   st_d = ST_CHK_LAST;
			ST_CHK_LAST:  st_d = (cur_q.tick >= rd_tick) ? ST_OUT : ST_SCAN_RD;
			ST_SCAN_RD:   st_d = ST_SCAN_CHK;
			ST_SCAN_CHK:  st_d = (scan_hit || scan_end) ? ST_DIV : ST_SCAN_RD;
			ST_DIV:       st_d = (dcnt_q == 6'd0) ? ST_LERP : ST_DIV;
			ST_LERP:      st_d = (c_q == 3'(NComp-1)) ? ST_OUT : ST_LERP;
			ST_OUT:       st_d = (rv_q && res_take) ? ST_IDLE : ST_OUT;
			default:      st_d = ST_IDLE;
		endcase
	end

	// scan: i_q is the upper entry of the pair, t0_q and p0_q hold the entry below
	// past both end checks a pair always encloses the tick, the last pair at worst
	assign scan_hit = (cur_q.tick >= t0_q) && (cur_q.tick <= rd_tick);
	assign scan_end = (CntW'(i_q) + 1'b1 >= n_q);

	// outputs of the sequencer
	assign cmd_take  = (st_q == ST_IDLE) && cmd_valid;
	assign res_valid = rv_q;
	assign res.has_markers = hm_q;
	assign res.comp        = out_q;

	// datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			rv_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (st_q != ST_OUT && st_d == ST_OUT) rv_q <= 1'b1;
			else if (rv_q && res_take) rv_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		unique case (st_q)
			ST_IDLE: begin
				cur_q <= cmd;
				n_q   <= n_sat;
				i_q   <= '0;
				hm_q  <= 1'b0;
				out_q <= '0;
			end
			ST_CHK_FIRST: begin
				hm_q  <= 1'b1;
				out_q <= rd_comp;
				t0_q  <= rd_tick;
				p0_q  <= rd_comp;
			end
			ST_CHK_LAST: begin
				out_q <= rd_comp;
				i_q   <= IdxW'(1);
			end
			ST_SCAN_CHK: begin
				if (scan_hit || scan_end) begin
					s_q <= rd_tick - t0_q;
					p1_q <= rd_comp;
					num_q <= {cur_q.tick - t0_q, FracBits'(0)};
				end else begin
					t0_q <= rd_tick;
					p0_q <= rd_comp;
					i_q  <= i_q + 1'b1;
				end
				rem_q  <= '0;
				dcnt_q <= 6'(DivN);
			end
			ST_DIV: begin
				if (dcnt_q != 6'd0) begin
					rem_q  <= ge ? rem_sh - {1'b0, s_q} : rem_sh;
					num_q  <= {num_q[DivN-2:0], ge};
					dcnt_q <= dcnt_q - 1'b1;
				end else begin
					if (s_q == '0) w_q <= '0;
					else if (num_q > DivN'(one_w)) w_q <= WW'(one_w);
					else w_q <= WW'(num_q);
				end
				c_q <= '0;
			end
			ST_LERP: begin
				out_q[c_q] <= CompW'($signed({p0_q[c_q][CompW-1], p0_q[c_q]}) + delta);
				c_q <= c_q + 1'b1;
			end
			default: ;
		endcase
	end

endmodule

// ----- src/keyframe_path_interpolator.sv -----
// ----------------------------------------------------------------------------
// keyframe_path_interpolator: camera keyframe table with linear lookup
// Front accepts items into a two-deep queue; back loads or answers queries.
//
//  channel | handshake     | beat
//  input   | push / full   | operation, entry_index, tick, seven components
//  result  | pop / empty   | has_markers, seven out_ components
//  config  | cfg_valid/rdy | marker_count
//
// A load is written to the table in the back's idle state. A query runs the
// one-port table scan up to the enclosing pair, the 48-step serial divider
// and 7 lerp steps; the first keyframe, the last, and an empty table skip
// ahead to the result. Reset clears control; table is undefined until
// written. The result register holds while pop is low; the queue absorbs
// two items meanwhile.
// ----------------------------------------------------------------------------
module keyframe_path_interpolator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic        operation,
	input  logic [5:0]  entry_index,
	input  logic [31:0] tick,
	input  logic signed [31:0] pos_x,
	input  logic signed [31:0] pos_y,
	input  logic signed [31:0] pos_z,
	input  logic signed [31:0] rot_x,
	input  logic signed [31:0] rot_y,
	input  logic signed [31:0] rot_z,
	input  logic signed [31:0] view_angle,
	output logic        empty,
	input  logic        pop,
	output logic        has_markers,
	output logic signed [31:0] out_pos_x,
	output logic signed [31:0] out_pos_y,
	output logic signed [31:0] out_pos_z,
	output logic signed [31:0] out_rot_x,
	output logic signed [31:0] out_rot_y,
	output logic signed [31:0] out_rot_z,
	output logic signed [31:0] out_view_angle,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [6:0]  cfg_data
);
	import kpi_pkg::*;

	cmd_t            in_cmd, q_cmd;
	logic            q_empty, q_take;
	logic            rv;
	res_t            r;
	logic [CntW-1:0] count_q;

	// configuration register
	assign cfg_ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) count_q <= '0;
		else if (cfg_valid) count_q <= cfg_data;
	end

	// front: pack the beat
	assign in_cmd.op   = op_t'(operation);
	assign in_cmd.idx  = entry_index;
	assign in_cmd.tick = tick;
	assign in_cmd.comp = {view_angle, rot_z, rot_y, rot_x, pos_z, pos_y, pos_x};

	kpi_cmd_fifo u_fifo (
		.clk(clk), .arst_n(arst_n),
		.wr_en(push), .wr_data(in_cmd), .full(full),
		.rd_en(q_take), .rd_data(q_cmd), .empty(q_empty)
	);

	kpi_back u_back (
		.clk(clk), .arst_n(arst_n), .count(count_q),
		.cmd_valid(!q_empty), .cmd(q_cmd), .cmd_take(q_take),
		.res_valid(rv), .res(r), .res_take(pop)
	);

	assign empty          = !rv;
	assign has_markers    = r.has_markers;
	assign out_pos_x      = r.comp[0];
	assign out_pos_y      = r.comp[1];
	assign out_pos_z      = r.comp[2];
	assign out_rot_x      = r.comp[3];
	assign out_rot_y      = r.comp[4];
	assign out_rot_z      = r.comp[5];
	assign out_view_angle = r.comp[6];

endmodule

// ----- src/kpi_checker.sv -----
// ----------------------------------------------------------------------------
// kpi_checker: port-level checks of the interpolator
// Watches the queue handshakes and the result register.
// ----------------------------------------------------------------------------
module kpi_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        empty,
	input logic        pop,
	input logic        has_markers,
	input logic [31:0] out_pos_x
);
	// a waiting result holds until popped
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !pop) |=> (!empty && $stable(out_pos_x) && $stable(has_markers)))
		else $error("result changed while waiting");

	// a popped result leaves the register empty in the following cycle, before the next
	a_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && pop) |=> empty)
		else $error("result reappeared right after pop");

	// an empty-table result carries zero values
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && !has_markers) |-> (out_pos_x == 32'd0))
		else $error("empty table gave non-zero value");

endmodule

bind keyframe_path_interpolator kpi_checker u_chk (
	.clk(clk), .arst_n(arst_n), .empty(empty), .pop(pop),
	.has_markers(has_markers), .out_pos_x(out_pos_x)
);

// ----- bench/keyframe_path_interpolator_tb.sv -----
// ----------------------------------------------------------------------------
// keyframe_path_interpolator_tb: self-checking bench for the keyframe lookup
// Loads keyframe tables, sets the marker count and fires queries through the
// push/full queue, predicting each answer and checking it beat by beat.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module keyframe_path_interpolator_tb;
	import kpi_pkg::*;

	typedef struct {
		op_t         op;
		logic [5:0]  idx;
		logic [31:0] tk;
		logic [31:0] comp [7];
	} beat_t;

	typedef struct {
		logic        hm;
		logic [31:0] comp [7];
	} answer_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic push = 1'b0, pop = 1'b0, cfg_valid = 1'b0;
	logic operation = 1'b0;
	logic [5:0] entry_index = '0;
	logic [31:0] tick = '0;
	logic signed [31:0] pos_x = '0, pos_y = '0, pos_z = '0;
	logic signed [31:0] rot_x = '0, rot_y = '0, rot_z = '0, view_angle = '0;
	logic [6:0] cfg_data = '0;
	logic full, empty, has_markers, cfg_ready;
	logic signed [31:0] out_pos_x, out_pos_y, out_pos_z;
	logic signed [31:0] out_rot_x, out_rot_y, out_rot_z, out_view_angle;

	keyframe_path_interpolator DUT (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// bench copy of the table and count
	logic [31:0] kf_tick [64];
	logic [31:0] kf_comp [64][7];
	logic [6:0]  count_sh;

	beat_t   pending_q [$];
	answer_t answers_q [$];
	int      errors = 0;
	int      send_idle = 0, recv_stall = 0;
	longint  cycles = 0;

	function automatic logic [31:0] lerp_one(logic [31:0] a, logic [31:0] b,
			longint unsigned w);
		longint p0, p1, prod;
		p0 = longint'($signed(a));
		p1 = longint'($signed(b));
		prod = (p1 - p0) * longint'(w) + 64'sd32768;
		return 32'(p0 + (prod >>> 16));
	endfunction

	function automatic answer_t predict_query(logic [31:0] t);
		answer_t r;
		int n, i0, i1;
		logic [31:0] d, s;
		longint unsigned w;
		n = (count_sh > 64) ? 64 : count_sh;
		r.hm = 1'b0;
		for (int c = 0; c < 7; c++) r.comp[c] = '0;
		if (n == 0) return r;
		r.hm = 1'b1;
		if (t <= kf_tick[0]) begin
			for (int c = 0; c < 7; c++) r.comp[c] = kf_comp[0][c];
			return r;
		end
		if (t >= kf_tick[n-1]) begin
			for (int c = 0; c < 7; c++) r.comp[c] = kf_comp[n-1][c];
			return r;
		end
		i0 = 0; i1 = 1;
		for (int i = 0; i + 1 < n; i++)
			if (t >= kf_tick[i] && t <= kf_tick[i+1]) begin
				i0 = i; i1 = i + 1; break;
			end
		d = t - kf_tick[i0];
		s = kf_tick[i1] - kf_tick[i0];
		if (s == 0) w = 0;
		else begin
			w = ({32'd0, d} << 16) / {32'd0, s};
			if (w > 65536) w = 65536;
		end
		for (int c = 0; c < 7; c++) r.comp[c] = lerp_one(kf_comp[i0][c], kf_comp[i1][c], w);
		return r;
	endfunction

	// driver: prediction happens at acceptance
	always @(posedge clk) begin
		if (push && !full) begin
			beat_t b;
			b = pending_q.pop_front();
			if (b.op == OP_LOAD) begin
				kf_tick[b.idx] <= b.tk;
				for (int c = 0; c < 7; c++) kf_comp[b.idx][c] <= b.comp[c];
			end else answers_q.push_back(predict_query(b.tk));
		end
		if (arst_n && pending_q.size() > 0 && ($urandom_range(99) >= send_idle
				|| (push && full))) begin
			if (push && !full && pending_q.size() == 0) push <= 1'b0;
			else begin
				beat_t b;
				b = (push && !full) ? pending_q[0] : pending_q[0];
				push <= 1'b1;
				operation <= b.op; entry_index <= b.idx; tick <= b.tk;
				pos_x <= b.comp[0]; pos_y <= b.comp[1]; pos_z <= b.comp[2];
				rot_x <= b.comp[3]; rot_y <= b.comp[4]; rot_z <= b.comp[5];
				view_angle <= b.comp[6];
			end
		end else push <= 1'b0;
	end

	// monitor
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (pop && !empty) begin
			logic [31:0] got [7];
			answer_t e;
			got = '{out_pos_x, out_pos_y, out_pos_z, out_rot_x, out_rot_y, out_rot_z,
				out_view_angle};
			if (answers_q.size() == 0) begin
				$display("%0t unexpected result beat", $time);
				errors++;
			end else begin
				e = answers_q.pop_front();
				if (has_markers !== e.hm) begin
					$display("%0t has_markers exp %b got %b", $time, e.hm, has_markers);
					errors++;
				end
				for (int c = 0; c < 7; c++)
					if (got[c] !== e.comp[c]) begin
						$display("%0t comp %0d exp %h got %h", $time, c, e.comp[c], got[c]);
						errors++;
					end
			end
		end
		pop <= arst_n && ($urandom_range(99) >= recv_stall);
	end

	task automatic add_load(int i, logic [31:0] t);
		beat_t b;
		b.op = OP_LOAD; b.idx = 6'(i); b.tk = t;
		for (int c = 0; c < 7; c++) b.comp[c] = $urandom;
		if ($urandom_range(3) == 0) b.comp[$urandom_range(6)] = 32'h8000_0000;
		if ($urandom_range(3) == 0) b.comp[$urandom_range(6)] = 32'h7fff_ffff;
		pending_q.push_back(b);
	endtask

	task automatic add_query(logic [31:0] t);
		beat_t b;
		b.op = OP_QUERY; b.idx = 6'($urandom); b.tk = t;
		for (int c = 0; c < 7; c++) b.comp[c] = $urandom;
		pending_q.push_back(b);
	endtask

	task automatic drain();
		wait (pending_q.size() == 0);
		while (answers_q.size() != 0 || push) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic set_count(int n);
		@(posedge clk);
		cfg_data <= 7'(n);
		cfg_valid <= 1'b1;
		do @(posedge clk); while (!cfg_ready);
		count_sh = 7'(n);
		cfg_valid <= 1'b0;
	endtask

	// builds a sorted table of n entries, then queries it
	task automatic table_phase(int n, int queries, bit wide);
		logic [31:0] t, lo, hi;
		t = wide ? $urandom_range(1000) : $urandom_range(50);
		for (int i = 0; i < n; i++) begin
			add_load(i, t);
			t = t + (wide ? $urandom_range(400_000_000 / 64) : $urandom_range(3) * $urandom_range(20));
		end
		drain();
		set_count(n);
		lo = kf_tick[0];
		hi = kf_tick[n-1];
		for (int q = 0; q < queries; q++) begin
			case ($urandom_range(9))
				0: add_query(lo > 0 ? lo - $urandom_range(lo > 5 ? 5 : lo) : 0);
				1: add_query(hi + $urandom_range(5));
				2: add_query(kf_tick[$urandom_range(n-1)]);
				3: add_query($urandom);
				default: add_query(lo + 32'($urandom_range(0, hi - lo)));
			endcase
		end
		drain();
	endtask

	initial begin
		int modes [4] = '{0, 77, 0, 7};
		int stalls [4] = '{0, 0, 77, 7};
		for (int i = 0; i < 64; i++) begin
			kf_tick[i] = '0;
			for (int c = 0; c < 7; c++) kf_comp[i][c] = '0;
		end
		count_sh = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;

		// directed: empty table, then extremes
		add_query(32'd0);
		add_query(32'hffff_ffff);
		add_load(0, 32'd100);
		add_load(1, 32'd100);
		add_load(2, 32'hffff_fff0);
		add_load(63, 32'hffff_ffff);
		drain();
		set_count(1);
		add_query(32'd0); add_query(32'd100); add_query(32'hffff_ffff);
		drain();
		set_count(3);
		add_query(32'd100); add_query(32'd101); add_query(32'h8000_0000);
		add_query(32'hffff_ffef); add_query(32'hffff_fff0);
		drain();
		// count beyond table size acts as the full table; unsorted end
		for (int i = 3; i < 63; i++) add_load(i, 32'hffff_fff0 + 32'(i % 2));
		drain();
		set_count(127);
		add_query(32'hffff_fffe); add_query(32'd50); add_query(32'd5000);
		drain();
		set_count(64);
		add_query(32'hffff_fff8);
		drain();

		// random phases
		for (int ph = 0; ph < 16; ph++) begin
			send_idle = modes[ph % 4];
			recv_stall = stalls[ph % 4];
			table_phase((ph % 5 == 0) ? 64 : $urandom_range(2, 12), 80, ph[0]);
		end
		send_idle = 0; recv_stall = 0;
		table_phase(2, 20, 1'b0);
		set_count(0);
		add_query($urandom);
		drain();

		if (errors == 0) $display("PASS");
		else $display("FAIL");
		$finish;
	end

	// watchdog
	always @(posedge clk)
		if (cycles > 3_000_000) begin
			$display("FAIL");
			$finish;
		end

endmodule
